// ===== rtl/core/lcdseq_pkg.sv =====
package lcdseq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_PUTC  = 3'd1;
  localparam logic [2:0] OP_GOTO  = 3'd2;
  localparam logic [2:0] OP_SLOT  = 3'd3;
  localparam logic [2:0] OP_GLYPH = 3'd4;

  localparam logic REG_PULSE_HOLD = 1'b0;
  localparam logic REG_INIT_WAIT  = 1'b1;

  localparam logic [15:0] PULSE_HOLD_RESET = 16'd60;
  localparam logic [15:0] INIT_WAIT_RESET  = 16'd6000;

  localparam logic [7:0] DDRAM_BASE = 8'h80;
  localparam logic [1:0] CGRAM_TAG  = 2'b01;

  localparam logic [2:0] INIT_LAST_BYTE = 3'd5;

  localparam logic [2:0] PH_HI_EN_HIGH = 3'd0;
  localparam logic [2:0] PH_HI_EN_LOW  = 3'd1;
  localparam logic [2:0] PH_LO_EN_HIGH = 3'd2;
  localparam logic [2:0] PH_LO_EN_LOW  = 3'd3;
  localparam logic [2:0] PH_WAIT       = 3'd4;

  typedef struct packed {
    logic       init;
    logic       rs;
    logic [7:0] data;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
  } lcdseq_job_t;

  typedef struct packed {
    logic        push;
    lcdseq_job_t job;
  } lcdseq_push_t;

  typedef struct packed {
    logic        valid;
    lcdseq_job_t job;
  } lcdseq_head_t;

  typedef struct packed {
    logic [15:0] pulse_hold;
    logic [15:0] init_wait;
  } lcdseq_cfg_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0, 3'd1, 3'd2: b = 8'h20;
      3'd3:             b = 8'h28;
      3'd4:             b = 8'h0c;
      3'd5:             b = 8'h01;
      default:          b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/lcdseq_cmd_if.sv =====
interface lcdseq_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] value;
  logic [7:0] col;
  logic [7:0] row;
  logic [2:0] slot;

  modport source (output valid, op, value, col, row, slot, input ready);
  modport sink (input valid, op, value, col, row, slot, output ready);
endinterface

// ===== rtl/core/lcdseq_bus_if.sv =====
interface lcdseq_bus_if;
  logic        valid;
  logic        ready;
  logic        reg_sel;
  logic        enable;
  logic [3:0]  nibble;
  logic [15:0] hold_us;
  logic        last;
  logic [7:0]  cursor_col;
  logic [7:0]  cursor_row;

  modport source (output valid, reg_sel, enable, nibble, hold_us, last, cursor_col,
                  cursor_row, input ready);
  modport sink (input valid, reg_sel, enable, nibble, hold_us, last, cursor_col,
                cursor_row, output ready);
endinterface

// ===== rtl/core/lcdseq_front.sv =====
module lcdseq_front (
  input  logic                      clk,
  input  logic                      rst,
  lcdseq_cmd_if.sink                cmd,
  input  logic                      queue_full,
  output lcdseq_pkg::lcdseq_push_t  push
);
  import lcdseq_pkg::*;

  logic [7:0] cur_col;
  logic [7:0] cur_row;
  logic [7:0] cur_col_next;
  logic [7:0] cur_row_next;
  logic       known_op;
  logic       accept;
  logic [7:0] goto_addr;

  assign cmd.ready = !queue_full;
  assign accept    = cmd.valid && cmd.ready;

  assign goto_addr = DDRAM_BASE + {cmd.row[1:0] - 2'd1, 6'd0} + cmd.col - 8'd1;

  always_comb begin
    known_op     = 1'b1;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    push.job     = '0;
    unique case (cmd.op)
      OP_INIT: begin
        push.job.init = 1'b1;
        cur_col_next  = '0;
        cur_row_next  = '0;
      end
      OP_PUTC: begin
        push.job.rs   = 1'b1;
        push.job.data = cmd.value;
        cur_col_next  = cur_col + 8'd1;
      end
      OP_GOTO: begin
        push.job.data = goto_addr;
        cur_col_next  = cmd.col;
        cur_row_next  = cmd.row;
      end
      OP_SLOT: begin
        push.job.data = {CGRAM_TAG, cmd.slot, 3'd0};
      end
      OP_GLYPH: begin
        push.job.rs   = 1'b1;
        push.job.data = cmd.value;
      end
      default: known_op = 1'b0;
    endcase
    push.job.cursor_col = cur_col_next;
    push.job.cursor_row = cur_row_next;
    push.push           = accept && known_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (push.push) begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
    end
  end
endmodule

// ===== rtl/core/lcdseq_queue.sv =====
module lcdseq_queue #(
  parameter int unsigned DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lcdseq_pkg::lcdseq_push_t  push,
  input  logic                      pop,
  output logic                      full,
  output lcdseq_pkg::lcdseq_head_t  head
);
  import lcdseq_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lcdseq_job_t        mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push.push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("Job queue count exceeds its depth.");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push.push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("Job queue count did not follow a lone push.");
endmodule

// ===== rtl/core/lcdseq_back.sv =====
module lcdseq_back (
  input  logic                      clk,
  input  logic                      rst,
  input  lcdseq_pkg::lcdseq_cfg_t   cfg,
  input  lcdseq_pkg::lcdseq_head_t  head,
  output logic                      pop,
  lcdseq_bus_if.source              bus
);
  import lcdseq_pkg::*;

  logic [2:0]  phase;
  logic [2:0]  byte_idx;
  logic        advance;
  logic        job_done;
  logic [7:0]  cur_byte;
  logic [3:0]  cur_nibble;
  logic        valid;
  logic        reg_sel;
  logic        enable;
  logic [3:0]  nibble;
  logic [15:0] hold_us;
  logic        last;
  logic [7:0]  cursor_col;
  logic [7:0]  cursor_row;

  assign advance    = head.valid && (!valid || bus.ready);
  assign cur_byte   = head.job.init ? init_byte(byte_idx) : head.job.data;
  assign cur_nibble = (phase == PH_HI_EN_HIGH || phase == PH_HI_EN_LOW) ?
                      cur_byte[7:4] : cur_byte[3:0];
  assign job_done   = head.job.init ? (phase == PH_WAIT && byte_idx == INIT_LAST_BYTE)
                                    : (phase == PH_LO_EN_LOW);
  assign pop        = advance && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      phase    <= PH_HI_EN_HIGH;
      byte_idx <= '0;
    end else begin
      if (advance) begin
        valid <= 1'b1;
        if (job_done) begin
          phase    <= PH_HI_EN_HIGH;
          byte_idx <= '0;
        end else if (phase == PH_WAIT) begin
          phase    <= PH_HI_EN_HIGH;
          byte_idx <= byte_idx + 3'd1;
        end else begin
          phase <= phase + 3'd1;
        end
      end else if (bus.ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      reg_sel    <= head.job.rs;
      enable     <= (phase == PH_HI_EN_HIGH || phase == PH_LO_EN_HIGH);
      nibble     <= cur_nibble;
      hold_us    <= (phase == PH_WAIT) ? cfg.init_wait : cfg.pulse_hold;
      last       <= job_done;
      cursor_col <= head.job.cursor_col;
      cursor_row <= head.job.cursor_row;
    end
  end

  assign bus.valid      = valid;
  assign bus.reg_sel    = reg_sel;
  assign bus.enable     = enable;
  assign bus.nibble     = nibble;
  assign bus.hold_us    = hold_us;
  assign bus.last       = last;
  assign bus.cursor_col = cursor_col;
  assign bus.cursor_row = cursor_row;

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    head.valid && !head.job.init |-> phase != PH_WAIT && byte_idx == '0)
    else $error("Byte job is in an init-only phase.");

  a_enable_cmd: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_WAIT |=> !enable && !reg_sel)
    else $error("Wait phase drives enable or data select.");
endmodule

// ===== rtl/core/char_lcd_4bit_write_sequencer_core.sv =====
// Channel  Dir  Modport      Payload
// cmd      in   cmd.sink     op, value, col, row, slot
// bus      out  bus.source   reg_sel, enable, nibble, hold_us, last, cursor_col, cursor_row
// cfg      in   plain write  cfg_we, cfg_index, cfg_data
//
// Jobs run one at a time: four output phases per byte write, thirty for init.
// The back sequencer emits at most one phase per cycle, stalling while bus.ready is low.
// Synchronous active-high reset empties the job queue and clears the cursor.
// The job queue lets the front keep taking requests while the bus side stalls, until full.
module char_lcd_4bit_write_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  lcdseq_cmd_if.sink    cmd,
  lcdseq_bus_if.source  bus
);
  import lcdseq_pkg::*;

  lcdseq_cfg_t  cfg;
  lcdseq_push_t push;
  lcdseq_head_t head;
  logic         queue_full;
  logic         pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_hold <= PULSE_HOLD_RESET;
      cfg.init_wait  <= INIT_WAIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_HOLD: cfg.pulse_hold <= cfg_data;
        REG_INIT_WAIT:  cfg.init_wait  <= cfg_data;
        default: ;
      endcase
    end
  end

  lcdseq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .queue_full (queue_full),
    .push       (push)
  );

  lcdseq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  lcdseq_back u_back (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .head (head),
    .pop  (pop),
    .bus  (bus)
  );
endmodule
